/* design/bitvector_acl_packet_classifier_defines.svh */
// ----------------------------------------------------------------------------
// bitvector acl classifier assertion macros
// shared concurrent checks for the classifier rtl
// ----------------------------------------------------------------------------
`ifndef BITVECTOR_ACL_PACKET_CLASSIFIER_DEFINES_SVH
`define BITVECTOR_ACL_PACKET_CLASSIFIER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define BVACL_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define BVACL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bvacl_pkg.sv */
// ----------------------------------------------------------------------------
// bvacl_pkg
// beat types, operation codes and fixed constants of the acl classifier
// ----------------------------------------------------------------------------
package bvacl_pkg;

   localparam int SLOT_W = 4;
   localparam int ADDR_W = 32;
   localparam int ENTRY_MASK_W = 64;
   localparam int RULE_W = 7;
   localparam int PROTO_W = 8;

   localparam logic [PROTO_W-1:0] ICMP_PROTO = 8'd1;

   typedef enum logic [1:0] {
      OP_CLASSIFY   = 2'd0,
      OP_WRITE_SRC  = 2'd1,
      OP_WRITE_DST  = 2'd2,
      OP_WRITE_RULE = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   operation;
      logic                     header_complete;
      logic [PROTO_W-1:0]       protocol;
      logic [ADDR_W-1:0]        src_addr;
      logic [ADDR_W-1:0]        dst_addr;
      logic [SLOT_W-1:0]        slot;
      logic [ADDR_W-1:0]        entry_key;
      logic [ENTRY_MASK_W-1:0]  entry_mask;
      logic                     entry_valid;
      logic [RULE_W-1:0]        rule_index;
      logic                     rule_drop;
   } req_type;

   typedef struct packed {
      logic              verdict;
      logic              src_hit;
      logic              dst_hit;
      logic [RULE_W-1:0] chosen_rule;
   } rsp_type;

   // write request into one address table
   typedef struct packed {
      logic                     en;
      logic [SLOT_W-1:0]        slot;
      logic [ADDR_W-1:0]        key;
      logic [ENTRY_MASK_W-1:0]  mask;
      logic                     valid;
   } tbl_wr_type;

endpackage

/* design/bvacl_table.sv */
// ----------------------------------------------------------------------------
// bvacl_table
// exact-match address table: parallel key compare, lowest matching slot wins
// ----------------------------------------------------------------------------
module bvacl_table #(
   parameter int ENTRIES   = 16,
   parameter int MASK_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bvacl_pkg::tbl_wr_type         wr,
   input  logic [bvacl_pkg::ADDR_W-1:0]  lookup_addr,
   output logic                          lookup_hit,
   output logic [MASK_BITS-1:0]          lookup_mask
);
   import bvacl_pkg::*;

   logic [ADDR_W-1:0]    key_ff  [ENTRIES];
   logic [MASK_BITS-1:0] mask_ff [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;

   logic [ENTRIES-1:0]   match;
   logic [ENTRIES-1:0]   first;

   // slots beyond the table depth never match a write
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (wr.en && (32'(wr.slot) == i)) begin
            key_ff[i]  <= wr.key;
            mask_ff[i] <= wr.mask[MASK_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (wr.en && (32'(wr.slot) == i)) begin
               valid_ff[i] <= wr.valid;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == lookup_addr);
      end
   end

   // isolate lowest matching slot
   assign first      = match & (~match + ENTRIES'(1));
   assign lookup_hit = |match;

   always_comb begin
      lookup_mask = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         lookup_mask = lookup_mask | (mask_ff[i] & {MASK_BITS{first[i]}});
      end
   end

endmodule

/* design/bitvector_acl_packet_classifier.sv */
// ----------------------------------------------------------------------------
// bitvector_acl_packet_classifier: bit-vector acl over ipv4 headers
// an accepted request beat passes the input register, then the result register, to its response beat
// throughput one beat per cycle while the output is not stalled; table lookup is one pass of parallel compares
// reset clears entry valid bits and rule actions; keys and masks hold garbage
// ----------------------------------------------------------------------------
module bitvector_acl_packet_classifier #(
   parameter int TABLE_ENTRIES = 16,
   parameter int MASK_BITS     = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bvacl_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bvacl_pkg::rsp_type  rsp_data
);
   import bvacl_pkg::*;
   `include "bitvector_acl_packet_classifier_defines.svh"

   // index width of the rule action vector (MASK_BITS rules plus empty key)
   localparam int ACT_W = $clog2(MASK_BITS + 1);
   localparam logic [RULE_W-1:0] EMPTY_RULE = RULE_W'(MASK_BITS);

   // input register stage
   logic     req_valid_ff;
   req_type  req_ff;

   // result register stage
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;

   // rule action bits, one per rule plus the empty key
   logic [MASK_BITS:0] rule_act_ff;

   logic out_busy;
   logic advance;
   logic load;

   tbl_wr_type src_wr;
   tbl_wr_type dst_wr;

   logic                 src_hit;
   logic                 dst_hit;
   logic [MASK_BITS-1:0] src_mask;
   logic [MASK_BITS-1:0] dst_mask;

   logic [MASK_BITS-1:0] common;
   logic [MASK_BITS-1:0] lowest;
   logic [RULE_W-1:0]    low_idx;
   logic [RULE_W-1:0]    chosen;
   logic                 lookup;
   logic                 both_hit;
   logic                 rule_wr;

   // ---- flow control ----
   // result register blocked means the input stage cannot move on;
   // an empty input stage still takes a beat while the output waits
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign advance   = !out_busy;
   assign load      = advance || !req_valid_ff;
   assign req_stall = req_valid_ff && out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (load) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= req_data;
      end
   end

   // ---- table writes ----
   // writes land when the beat leaves the input stage, so the next beat
   // already sees the updated tables
   always_comb begin
      src_wr.en    = req_valid_ff && advance && (req_ff.operation == OP_WRITE_SRC);
      src_wr.slot  = req_ff.slot;
      src_wr.key   = req_ff.entry_key;
      src_wr.mask  = req_ff.entry_mask;
      src_wr.valid = req_ff.entry_valid;
      dst_wr       = src_wr;
      dst_wr.en    = req_valid_ff && advance && (req_ff.operation == OP_WRITE_DST);
   end

   assign rule_wr = req_valid_ff && advance && (req_ff.operation == OP_WRITE_RULE);

   // rule indices above the empty key match no bit and are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_act_ff <= '0;
      end else if (rule_wr) begin
         for (int i = 0; i <= MASK_BITS; i++) begin
            if (req_ff.rule_index == RULE_W'(i)) begin
               rule_act_ff[i] <= req_ff.rule_drop;
            end
         end
      end
   end

   // ---- lookups, both tables in parallel ----
   bvacl_table #(
      .ENTRIES   (TABLE_ENTRIES),
      .MASK_BITS (MASK_BITS)
   ) u_src_table (
      .clock       (clock),
      .reset       (reset),
      .wr          (src_wr),
      .lookup_addr (req_ff.src_addr),
      .lookup_hit  (src_hit),
      .lookup_mask (src_mask)
   );

   bvacl_table #(
      .ENTRIES   (TABLE_ENTRIES),
      .MASK_BITS (MASK_BITS)
   ) u_dst_table (
      .clock       (clock),
      .reset       (reset),
      .wr          (dst_wr),
      .lookup_addr (req_ff.dst_addr),
      .lookup_hit  (dst_hit),
      .lookup_mask (dst_mask)
   );

   // ---- rule selection ----
   // lowest common rule: isolate the lowest set bit, then encode it by
   // or-ing the index of each one-hot position
   assign common = src_mask & dst_mask;
   assign lowest = common & (~common + MASK_BITS'(1));

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < MASK_BITS; i++) begin
         low_idx = low_idx | ({RULE_W{lowest[i]}} & RULE_W'(i));
      end
   end

   // only complete icmp headers go through the tables
   assign lookup   = (req_ff.operation == OP_CLASSIFY) && req_ff.header_complete
                     && (req_ff.protocol == ICMP_PROTO);
   assign both_hit = lookup && src_hit && dst_hit;
   assign chosen   = (both_hit && (|common)) ? low_idx : EMPTY_RULE;

   always_comb begin
      rsp_in.src_hit     = lookup && src_hit;
      rsp_in.dst_hit     = lookup && dst_hit;
      rsp_in.chosen_rule = chosen;
      rsp_in.verdict     = both_hit && rule_act_ff[chosen[ACT_W-1:0]];
   end

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- checks ----
   `BVACL_ASSERT_IMPLIES(a_drop_needs_hits, clock, reset, rsp_valid_ff && rsp_ff.verdict, rsp_ff.src_hit && rsp_ff.dst_hit, "drop verdict without both table hits")
   `BVACL_ASSERT_IMPLIES(a_rule_needs_hits, clock, reset, rsp_valid_ff && (rsp_ff.chosen_rule != EMPTY_RULE), rsp_ff.src_hit && rsp_ff.dst_hit, "rule chosen without both table hits")
   `BVACL_ASSERT_IMPLIES(a_rule_in_range, clock, reset, rsp_valid_ff, rsp_ff.chosen_rule <= EMPTY_RULE, "chosen rule beyond empty key")
   `BVACL_ASSERT_NEXT(a_input_holds, clock, reset, req_valid_ff && out_busy, req_valid_ff && $stable(req_ff), "input stage lost a beat while output stalled")
   `BVACL_ASSERT_NEXT(a_write_result, clock, reset, req_valid_ff && advance && (req_ff.operation == OP_WRITE_RULE), rsp_valid_ff && !rsp_ff.verdict && (rsp_ff.chosen_rule == EMPTY_RULE), "write beat gave a non-neutral result")

endmodule
